### hdl/b60id_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b60id_pkg
// Shared types, constants and the base-60 digit lookup for the id decoder.
// ----------------------------------------------------------------------------
package b60id_pkg;

    localparam int unsigned B60_ID_LENGTH    = 18;
    localparam int unsigned B60_POS_W        = 5;
    localparam int unsigned B60_DIGIT_W      = 6;
    localparam int unsigned B60_LIMIT_W      = 16;
    localparam int unsigned B60_VALUE_W      = 81;
    localparam int unsigned B60_VHIGH_W      = 17;
    localparam int unsigned B60_HIGH_ID_W    = 32;
    localparam int unsigned B60_LOW_ID_W     = 64;
    localparam int unsigned B60_Q_DEPTH      = 2;

    localparam logic [B60_LIMIT_W-1:0] B60_LIMIT_RESET = 16'd36000;
    localparam logic [B60_POS_W-1:0]   B60_POS_FIRST   = 5'd0;
    localparam logic [B60_POS_W-1:0]   B60_POS_BKT_MSD = 5'd1;
    localparam logic [B60_POS_W-1:0]   B60_POS_BKT_LSD = 5'd3;
    localparam logic [B60_POS_W-1:0]   B60_POS_VAL_MSD = 5'd4;
    localparam logic [B60_POS_W-1:0]   B60_POS_LAST    = 5'd17;
    localparam logic [7:0]             B60_PREFIX_CHAR = 8'h5f;  // '_'

    // One classified character handed from the front to the back.
    typedef struct packed {
        logic [B60_DIGIT_W-1:0] digit;
        logic                   clr;        // first character: clear accumulators
        logic                   acc_bucket; // shift digit into bucket
        logic                   acc_value;  // shift digit into value
        logic                   last;       // final character: emit result
        logic                   err;        // id has an error so far
    } t_entry;

    // Result of the alphabet lookup.
    typedef struct packed {
        logic                   bad;
        logic [B60_DIGIT_W-1:0] value;
    } t_digit;

    // Base-60 alphabet: 0-9, a-z, A-Z without O and Q.
    function automatic t_digit digit_value(input logic [7:0] c);
        t_digit r;
        r.bad   = 1'b0;
        r.value = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r.value = 6'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h7a) begin
            r.value = 6'(c - 8'h61 + 8'd10);
        end else if (c >= 8'h41 && c <= 8'h4e) begin
            r.value = 6'(c - 8'h41 + 8'd36);
        end else if (c == 8'h50) begin
            r.value = 6'd50;
        end else if (c >= 8'h52 && c <= 8'h5a) begin
            r.value = 6'(c - 8'h52 + 8'd51);
        end else begin
            r.bad = 1'b1;
        end
        return r;
    endfunction

endpackage

### hdl/b60id_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b60id_front
// Tracks the character position and error state, classifies each request.
// ----------------------------------------------------------------------------
module b60id_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic [7:0]            i_char_in,
    input  logic                  i_restart,
    output b60id_pkg::t_entry     o_entry
);
    import b60id_pkg::*;

    logic [B60_POS_W-1:0] r_pos, n_pos;
    logic                 r_err, n_err;
    logic [B60_POS_W-1:0] pos;
    t_digit               dig;
    logic                 byte_bad;

    always_comb begin
        pos = i_restart ? B60_POS_FIRST : r_pos;
        dig = digit_value(i_char_in);

        if (pos == B60_POS_FIRST) begin
            byte_bad = (i_char_in != B60_PREFIX_CHAR);
        end else if (dig.bad) begin
            byte_bad = 1'b1;
        end else if ((pos == B60_POS_BKT_MSD || pos == B60_POS_VAL_MSD)
                     && dig.value >= 6'd10) begin
            byte_bad = 1'b1;
        end else begin
            byte_bad = 1'b0;
        end

        o_entry.digit      = dig.value;
        o_entry.clr        = (pos == B60_POS_FIRST);
        o_entry.acc_bucket = !byte_bad && pos >= B60_POS_BKT_MSD
                             && pos <= B60_POS_BKT_LSD;
        o_entry.acc_value  = !byte_bad && pos >= B60_POS_VAL_MSD;
        o_entry.last       = (pos == B60_POS_LAST);
        o_entry.err        = byte_bad || (pos != B60_POS_FIRST && r_err);

        n_pos = (pos == B60_POS_LAST) ? B60_POS_FIRST : pos + 5'd1;
        n_err = o_entry.err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= B60_POS_FIRST;
            r_err <= 1'b0;
        end else if (i_push) begin
            r_pos <= n_pos;
            r_err <= n_err;
        end
    end

endmodule

### hdl/b60id_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b60id_queue
// Small FIFO of classified characters between front and back.
// ----------------------------------------------------------------------------
module b60id_queue #(
    parameter int unsigned DEPTH = b60id_pkg::B60_Q_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  b60id_pkg::t_entry     i_data,
    output logic                  o_ready,
    output logic                  o_valid,
    output b60id_pkg::t_entry     o_data,
    input  logic                  i_pop
);
    import b60id_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    assign o_ready = (r_count != FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### hdl/b60id_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b60id_back
// Base-60 accumulators, limit check and registered result stage.
// ----------------------------------------------------------------------------
module b60id_back (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_q_valid,
    input  b60id_pkg::t_entry                      i_q_data,
    output logic                                   o_q_pop,
    input  logic [b60id_pkg::B60_LIMIT_W-1:0]      i_bucket_limit,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic                                   o_id_ok,
    output logic [b60id_pkg::B60_HIGH_ID_W-1:0]    o_high_id,
    output logic [b60id_pkg::B60_LOW_ID_W-1:0]     o_low_id
);
    import b60id_pkg::*;

    logic [B60_LIMIT_W-1:0]   r_bucket, n_bucket;
    logic [B60_VALUE_W-1:0]   r_value, n_value;
    logic [B60_LIMIT_W-1:0]   base_b;
    logic [B60_VALUE_W-1:0]   base_v;
    logic [21:0]              bprod;
    logic                     ok;
    logic [B60_HIGH_ID_W-1:0] high_sum;

    logic                     r_out_valid;
    logic                     r_id_ok;
    logic [B60_HIGH_ID_W-1:0] r_high_id;
    logic [B60_LOW_ID_W-1:0]  r_low_id;

    // A final character needs a free output slot; others drain freely.
    assign o_q_pop = i_q_valid && (!i_q_data.last || !r_out_valid || i_out_ready);

    always_comb begin
        base_b = i_q_data.clr ? '0 : r_bucket;
        base_v = i_q_data.clr ? '0 : r_value;
        bprod  = {6'b0, base_b} * 22'd60;

        n_bucket = base_b;
        if (i_q_data.acc_bucket) begin
            n_bucket = bprod[B60_LIMIT_W-1:0] + {10'b0, i_q_data.digit};
        end

        // x*60 = x*64 - x*4, mod 2^81
        n_value = base_v;
        if (i_q_data.acc_value) begin
            n_value = (base_v << 6) - (base_v << 2)
                      + {{(B60_VALUE_W-B60_DIGIT_W){1'b0}}, i_q_data.digit};
        end

        ok = !i_q_data.err && n_bucket != '0 && n_bucket < i_bucket_limit;
        high_sum = {n_bucket, 16'b0}
                   + {15'b0, n_value[B60_VALUE_W-1:B60_LOW_ID_W]};
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_bucket <= n_bucket;
            r_value  <= n_value;
        end
        if (o_q_pop && i_q_data.last) begin
            r_id_ok   <= ok;
            r_high_id <= ok ? high_sum : '0;
            r_low_id  <= ok ? n_value[B60_LOW_ID_W-1:0] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_q_pop && i_q_data.last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_id_ok     = r_id_ok;
    assign o_high_id   = r_high_id;
    assign o_low_id    = r_low_id;

endmodule

### hdl/base60_id_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base60_id_decoder_core
// Streaming decoder for 18-character base-60 object identifiers.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready): one request per identifier
//   byte, i_char_in plus i_restart. i_restart forces the byte to position 0.
//   After the 18th byte one result request leaves on the output channel
//   (o_out_valid / i_out_ready): o_id_ok, o_high_id, o_low_id. Invalid ids
//   give zero id fields. Other bytes produce nothing.
//   Config channel (i_cfg_valid / o_cfg_ready): writes bucket_limit; it is
//   always ready and must only be written while the block is idle.
//   Throughput: one byte per cycle while the queue has room; the back end
//   does the multiply-by-60 (shift and subtract) of the 81-bit value in
//   combinational logic. With the output free, the accepted 18th byte is
//   written into the queue; the back end then pops it and loads the output
//   register on the same edge, which raises o_out_valid.
//   Reset (synchronous, active low) empties the queue, drops any partial id,
//   clears the output valid and loads bucket_limit with 36000.
//   When the receiver stalls, the result waits in the output register while
//   the front keeps taking bytes until the queue fills; o_in_ready then drops.
// ----------------------------------------------------------------------------
module base60_id_decoder_core #(
    parameter int unsigned Q_DEPTH = b60id_pkg::B60_Q_DEPTH
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // configuration write
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [b60id_pkg::B60_LIMIT_W-1:0]      i_cfg_data,
    // character input
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic [7:0]                             i_char_in,
    input  logic                                   i_restart,
    // result output
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic                                   o_id_ok,
    output logic [b60id_pkg::B60_HIGH_ID_W-1:0]    o_high_id,
    output logic [b60id_pkg::B60_LOW_ID_W-1:0]     o_low_id
);
    import b60id_pkg::*;

    logic [B60_LIMIT_W-1:0] r_bucket_limit;
    logic                   push;
    logic                   q_ready;
    logic                   q_valid;
    logic                   q_pop;
    t_entry                 front_entry;
    t_entry                 q_entry;

    // Bucket limit register; only write it while idle: the block does not check.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_limit <= B60_LIMIT_RESET;
        end else if (i_cfg_valid) begin
            r_bucket_limit <= i_cfg_data;
        end
    end

    assign o_in_ready = q_ready;
    assign push       = i_in_valid && q_ready;

    // Front: position tracking and character classification.
    b60id_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_char_in (i_char_in),
        .i_restart (i_restart),
        .o_entry   (front_entry)
    );

    // Decoupling queue.
    b60id_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_entry),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_data  (q_entry),
        .i_pop   (q_pop)
    );

    // Back: accumulation and result register.
    b60id_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_data       (q_entry),
        .o_q_pop        (q_pop),
        .i_bucket_limit (r_bucket_limit),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_id_ok        (o_id_ok),
        .o_high_id      (o_high_id),
        .o_low_id       (o_low_id)
    );

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - base60_id_decoder_core regression
// Streams 18-byte identifiers into the decoder, one byte per request, and
// checks every decoded id against a behavioral model kept in this bench.
// Covers the alphabet edges, malformed ids, restart handling, bucket limit
// settings, back-pressure and constrained-looking random traffic.
// ----------------------------------------------------------------------------
module tb;

    import b60id_pkg::*;

    // Bench knobs
    localparam int unsigned STALL_LIMIT   = 2000; // idle cycles before giving up
    localparam int unsigned SINK_HOLD_LEN = 200;  // long receiver hold-off
    localparam int unsigned SETTLE_CYCLES = 4;    // lets the pipe settle before a limit write
    localparam int unsigned NOT_A_DIGIT   = 60;
    localparam int unsigned IDLE_PCT      = 23;
    localparam int unsigned SEQS_PER_PASS = 2;

    typedef struct packed {
        bit                     ok;
        bit [B60_HIGH_ID_W-1:0] high;
        bit [B60_LOW_ID_W-1:0]  low;
    } t_decoded_id;

    // Base-60 digit order: 0-9, a-z, A-Z minus O and Q.
    string alphabet = "0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNPRSTUVWXYZ";

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [B60_LIMIT_W-1:0]   i_cfg_data;
    logic                     i_in_valid;
    logic                     o_in_ready;
    logic [7:0]               i_char_in;
    logic                     i_restart;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    logic                     o_id_ok;
    logic [B60_HIGH_ID_W-1:0] o_high_id;
    logic [B60_LOW_ID_W-1:0]  o_low_id;

    base60_id_decoder_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_char_in   (i_char_in),
        .i_restart   (i_restart),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_id_ok     (o_id_ok),
        .o_high_id   (o_high_id),
        .o_low_id    (o_low_id)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Decoder model state. Mirrors what the block must hold between bytes:
    // position within the id, partial bucket, partial 81-bit value, and a
    // sticky error flag. limit_reg tracks the bucket_limit register.
    // ------------------------------------------------------------------------
    bit [B60_POS_W-1:0]    id_pos;
    bit [B60_LIMIT_W-1:0]  bucket_sum;
    bit [B60_VALUE_W-1:0]  value_sum;
    bit                    id_bad;
    bit [B60_LIMIT_W-1:0]  limit_reg = B60_LIMIT_RESET;

    t_decoded_id pending_ids[$];  // decoded ids still owed by the block
    int unsigned fail_count  = 0;
    int unsigned stall_cycles = 0;

    // Shared traffic controls
    bit          gaps_on  = 1'b1;  // random idle cycles on both channels
    bit          hold_req = 1'b0;  // ask the receiver for a long hold-off
    bit          hold_armed = 1'b0;
    int unsigned hold_left  = 0;

    function automatic int unsigned char_digit(input bit [7:0] c);
        for (int i = 0; i < 60; i++) begin
            if (alphabet[i] == c) return i;
        end
        return NOT_A_DIGIT;
    endfunction

    function automatic void clear_id();
        id_pos     = '0;
        bucket_sum = '0;
        value_sum  = '0;
        id_bad     = 1'b0;
    endfunction

    // Advance the model by one accepted byte. Returns 1 when the byte
    // completes an id, with the decoded id in res.
    function automatic bit decode_char(input bit [7:0] c, input bit rs,
                                       output t_decoded_id res);
        int unsigned d;
        d   = char_digit(c);
        res = '0;
        // restart, or the byte after a finished id, opens a new id
        if (rs || id_pos >= B60_ID_LENGTH) clear_id();

        if (id_pos == B60_POS_FIRST) begin
            if (c != B60_PREFIX_CHAR) id_bad = 1'b1;
        end else if (d == NOT_A_DIGIT) begin
            id_bad = 1'b1;
        end else if ((id_pos == B60_POS_BKT_MSD || id_pos == B60_POS_VAL_MSD) && d >= 10) begin
            // leading digit of bucket and of value are decimal only
            id_bad = 1'b1;
        end else if (id_pos <= B60_POS_BKT_LSD) begin
            bucket_sum = B60_LIMIT_W'(bucket_sum * 60 + d);
        end else begin
            value_sum = value_sum * 60 + d;   // wraps at 81 bits
        end

        if (id_pos != B60_POS_LAST) begin
            id_pos = id_pos + 1'b1;
            return 1'b0;
        end

        if (!id_bad && bucket_sum != 0 && bucket_sum < limit_reg) begin
            res.ok   = 1'b1;
            res.high = B60_HIGH_ID_W'({bucket_sum, 16'h0000} +
                                      value_sum[B60_VALUE_W-1:B60_LOW_ID_W]);
            res.low  = value_sum[B60_LOW_ID_W-1:0];
        end
        clear_id();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: everything is sampled at the rising edge, before the DUT's
    // own updates land. Result check comes first; a byte accepted on this
    // edge can never produce a result on the same edge.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_decoded_id want;
        t_decoded_id model_out;
        if (!i_rst_n) begin
            limit_reg = B60_LIMIT_RESET;
            clear_id();
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (pending_ids.size() == 0) begin
                    $error("result request with no id outstanding: ok=%0b high=%0h low=%0h",
                           o_id_ok, o_high_id, o_low_id);
                    fail_count++;
                end else begin
                    want = pending_ids.pop_front();
                    if (o_id_ok !== want.ok) begin
                        $error("id_ok: expected %0b, got %0b", want.ok, o_id_ok);
                        fail_count++;
                    end
                    if (o_high_id !== want.high) begin
                        $error("high_id: expected %0h, got %0h", want.high, o_high_id);
                        fail_count++;
                    end
                    if (o_low_id !== want.low) begin
                        $error("low_id: expected %0h, got %0h", want.low, o_low_id);
                        fail_count++;
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) limit_reg = i_cfg_data;
            if (i_in_valid && o_in_ready) begin
                if (decode_char(i_char_in, i_restart, model_out))
                    pending_ids.push_back(model_out);
            end
        end
    end

    // Watchdog: any accepted request on any channel resets the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("base60_id_decoder_core regression: fail");
            $finish;
        end
    end

    // Receiver: random ready, plus a long hold-off when the test asks for one.
    // The hold-off is counted here so the sender keeps pushing meanwhile.
    always @(negedge i_clk) begin
        if (hold_req && !hold_armed) hold_left = SINK_HOLD_LEN;
        hold_armed = hold_req;
        if (hold_left > 0) begin
            i_out_ready = 1'b0;
            hold_left--;
        end else begin
            i_out_ready = !gaps_on || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------------
    // Sender side. All drive happens on the falling edge.
    // ------------------------------------------------------------------------
    task automatic send_char(input bit [7:0] c, input bit rs);
        while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_char_in  = c;
        i_restart  = rs;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    // Send a string as an id; optionally overwrite one byte with a raw value.
    task automatic send_id(input string s, input bit rs,
                           input int poke_at = -1, input bit [7:0] poke = 8'h00);
        for (int i = 0; i < s.len(); i++) begin
            send_char((i == poke_at) ? poke : s[i], (i == 0) ? rs : 1'b0);
        end
    endtask

    task automatic wait_results_drained();
        while (pending_ids.size() != 0) @(negedge i_clk);
    endtask

    // Limit writes only with the block idle: all results in, pipe settled.
    task automatic write_limit(input bit [B60_LIMIT_W-1:0] v);
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // One random sequence: mostly well-formed ids with random digits; some
    // get a corrupted byte, some are cut short, some are raw noise bytes.
    // left_open reports a partial id left in the block.
    task automatic send_random_seq(input bit rs_first, output bit left_open);
        bit [7:0]    id_chars [B60_ID_LENGTH];
        int unsigned kind;
        int unsigned cut;
        id_chars[0] = B60_PREFIX_CHAR;
        for (int i = 1; i < B60_ID_LENGTH; i++) begin
            id_chars[i] = alphabet[$urandom_range(59)];
        end
        id_chars[B60_POS_BKT_MSD] = 8'("0" + $urandom_range(9));
        id_chars[B60_POS_VAL_MSD] = 8'("0" + $urandom_range(9));
        kind      = $urandom_range(99);
        cut       = B60_ID_LENGTH;
        left_open = 1'b0;
        if (kind < 12) begin
            id_chars[$urandom_range(B60_ID_LENGTH-1)] = 8'($urandom_range(255));
        end else if (kind < 20) begin
            cut       = $urandom_range(1, B60_ID_LENGTH-1);
            left_open = 1'b1;
        end else if (kind < 26) begin
            repeat ($urandom_range(1, 5))
                send_char(8'($urandom_range(255)), 1'($urandom_range(1)));
            left_open = 1'b1;
            cut       = 0;
        end
        for (int i = 0; i < cut; i++) send_char(id_chars[i], (i == 0) ? rs_first : 1'b0);
    endtask

    task automatic random_pass(input bit [B60_LIMIT_W-1:0] lim);
        bit open_id;
        open_id = 1'b1;
        write_limit(lim);
        repeat (SEQS_PER_PASS) begin
            // a partial id left behind gets flushed by a restart most of the time
            send_random_seq(open_id ? ($urandom_range(3) != 0) : 1'($urandom_range(1)),
                            open_id);
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset limit 36000: largest bucket and value, smallest bucket, alphabet edges.
    task automatic test_good_ids();
        send_id("_9ZZ9ZZZZZZZZZZZZZ", 1'b1);   // bucket 35999, value lead 9 then all 59s
        send_id("_0010123456789abcd", 1'b0);   // bucket 1, no restart after id
        send_id("_1AN5PRSZmnopqrstu", 1'b0);   // capitals around the O/Q holes
        send_id("_0010000000000000z", 1'b1);
    endtask

    // Every way an id can be rejected, apart from a bucket at or above the limit.
    task automatic test_bad_ids();
        send_id("_0009ZZZZZZZZZZZZZ", 1'b1);   // zero bucket
        send_id("-0010123456789abcd", 1'b1);   // wrong prefix
        send_id("_a010123456789abcd", 1'b1);   // letter as bucket lead digit
        send_id("_001a123456789abcd", 1'b1);   // letter as value lead digit
        send_id("_0010123456789abcO", 1'b1);   // capital O not in alphabet
        send_id("_0010Q23456789abcd", 1'b1);   // capital Q not in alphabet
        send_id("_0010123456789abcd", 1'b1, 2, 8'h00);   // NUL inside bucket
        send_id("_0010123456789abcd", 1'b1, 17, 8'hff);  // top byte value at the end
    endtask

    // Restart drops a partial id; a stray restart-less byte after an id
    // still starts a new one.
    task automatic test_restart();
        send_id("_9ZZ9ZZZZ", 1'b1);
        send_id("_0010123456789abcd", 1'b1);
        send_id("_9ZZ9", 1'b0);
        send_id("_1AN5PRSZmnopqrstu", 1'b1);
    endtask

    // Bucket limit extremes and a boundary just below/at the limit.
    task automatic test_limit_settings();
        write_limit(16'd1);        // nothing is below 1 except 0, which is invalid
        send_id("_0010123456789abcd", 1'b1);
        write_limit(16'd0);        // every bucket rejected
        send_id("_0010123456789abcd", 1'b1);
        write_limit(16'hffff);
        send_id("_9ZZ9ZZZZZZZZZZZZZ", 1'b1);
        write_limit(16'd1000);
        send_id("_0gE0123456789abcd", 1'b1);  // bucket 1000: at the limit
        send_id("_0gD0123456789abcd", 1'b1);  // bucket 999: just below
        write_limit(B60_LIMIT_RESET);
    endtask

    // Receiver holds off while the sender keeps going, so the internal queue
    // fills and input ready has to drop.
    task automatic test_backpressure();
        bit open_id;
        gaps_on  = 1'b0;
        hold_req = 1'b1;
        @(negedge i_clk);
        repeat (4) send_random_seq(1'b1, open_id);
        hold_req = 1'b0;
        gaps_on  = 1'b1;
    endtask

    // Random traffic over several limit settings; one pass without idling,
    // and a pause between two passes until everything owed has come back.
    task automatic test_random();
        random_pass(16'($urandom_range(1, 36000)));
        gaps_on = 1'b0;
        random_pass(16'hffff);
        gaps_on = 1'b1;
        random_pass(16'($urandom_range(0, 65535)));
        wait_results_drained();
        random_pass(B60_LIMIT_RESET);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_char_in   = '0;
        i_restart   = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_good_ids();
        test_bad_ids();
        test_restart();
        test_limit_settings();
        test_backpressure();
        test_random();

        // let the last results drain, then watch for strays
        wait_results_drained();
        repeat (8) @(posedge i_clk);
        fail_count += pending_ids.size();
        if (fail_count == 0) begin
            $display("base60_id_decoder_core regression: pass");
        end else begin
            $display("base60_id_decoder_core regression: fail");
        end
        $finish;
    end

endmodule
